[sv/interval_timer_interrupt_flags_unit_macros.svh]
// Assertion helpers used by the checker file.
`ifndef INTERVAL_TIMER_INTERRUPT_FLAGS_UNIT_MACROS_SVH
`define INTERVAL_TIMER_INTERRUPT_FLAGS_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ITIF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itif: implication check failed");

// next-cycle implication, disabled during reset
`define ITIF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itif: next-cycle check failed");

`endif

[sv/itif_pkg.sv]
package itif_pkg;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_RAISE   = 3'd1,
    ACT_WR_BYTE = 3'd2,
    ACT_WR_WORD = 3'd3,
    ACT_RD_BYTE = 3'd4,
    ACT_RD_WORD = 3'd5
  } itif_action_e;

  localparam int unsigned NumSrc   = 5;
  localparam int unsigned TimerBit = 3;
  localparam int unsigned CntW     = 33;
  localparam int unsigned ClrLsb   = 8;   // clear bits 8..12 of a flag word write
  localparam int unsigned ClrMsb   = 12;

  localparam logic [2:0]  MaxSrc      = 3'd4;
  localparam logic [23:0] PrescaleAddr = 24'hF00050;
  localparam logic [23:0] DivideAddr   = 24'hF00052;
  localparam logic [23:0] IntFlagAddr  = 24'hF000E0;
  localparam logic [23:0] HcAddr       = 24'hF00004;
  localparam logic [23:0] MirrorLo     = 24'hF08000;
  localparam logic [23:0] MirrorHi     = 24'hF0BFFF;
  localparam logic [23:0] MirrorMask   = 24'hFF7FFF;
  localparam logic [23:0] WindowLo     = 24'hF00000;
  localparam logic [23:0] WindowHi     = 24'hF03FFF;
  localparam logic [13:0] IcHiOff      = 14'h00E0;
  localparam logic [13:0] IcLoOff      = 14'h00E1;

  // byte-lane writes to prescaler and divider
  typedef struct packed {
    logic       ps_hi_we;
    logic       ps_lo_we;
    logic       dv_hi_we;
    logic       dv_lo_we;
    logic [7:0] ps_hi;
    logic [7:0] ps_lo;
    logic [7:0] dv_hi;
    logic [7:0] dv_lo;
  } itif_tmr_wr_t;

  // byte-lane writes to the interrupt control word plus flag clears
  typedef struct packed {
    logic              hi_we;
    logic              lo_we;
    logic [7:0]        hi;
    logic [7:0]        lo;
    logic [NumSrc-1:0] clr;
  } itif_ic_wr_t;

  function automatic logic left_out(input logic [23:0] a);
    left_out = (a >= 24'hF02100 && a < 24'hF02120) ||
               (a >= 24'hF03000 && a < 24'hF04000) ||
               (a >= 24'hF02200 && a < 24'hF022A0);
  endfunction

  function automatic logic [7:0] ic_byte(input logic [13:0] off, input logic [15:0] ic);
    if (off == IcHiOff) begin
      ic_byte = ic[15:8];
    end else if (off == IcLoOff) begin
      ic_byte = ic[7:0];
    end else begin
      ic_byte = 8'h00;
    end
  endfunction

endpackage

[sv/itif_bus_dec.sv]
module itif_bus_dec (
  input  logic [2:0]                      action_i,
  input  logic [23:0]                     address_i,
  input  logic [15:0]                     write_data_i,
  input  logic [itif_pkg::NumSrc-1:0]     pending_i,
  input  logic [15:0]                     int_control_i,
  input  logic [15:0]                     prescale_i,
  input  logic [15:0]                     divide_i,
  output itif_pkg::itif_tmr_wr_t          tmr_wr_o,
  output itif_pkg::itif_ic_wr_t           ic_wr_o,
  output logic [15:0]                     read_data_o
);

  logic [23:0] mapped;
  logic        wr_ok;
  logic [13:0] off;
  logic [13:0] off1;
  logic [13:0] roff;
  logic [13:0] roff1;

  always_comb begin
    mapped = address_i;
    if (address_i >= itif_pkg::MirrorLo && address_i <= itif_pkg::MirrorHi) begin
      mapped = address_i & itif_pkg::MirrorMask;
    end
    wr_ok = (mapped >= itif_pkg::WindowLo) && (mapped <= itif_pkg::WindowHi) &&
            !itif_pkg::left_out(mapped);
    off  = mapped[13:0];
    off1 = off + 14'd1;
  end

  always_comb begin
    tmr_wr_o = '0;
    ic_wr_o  = '0;
    unique case (action_i)
      itif_pkg::ACT_WR_BYTE: begin
        if (wr_ok) begin
          if (mapped == itif_pkg::PrescaleAddr) begin
            tmr_wr_o.ps_hi_we = 1'b1;
            tmr_wr_o.ps_hi    = write_data_i[7:0];
          end else if (mapped == itif_pkg::PrescaleAddr + 24'd1) begin
            tmr_wr_o.ps_lo_we = 1'b1;
            tmr_wr_o.ps_lo    = write_data_i[7:0];
          end else if (mapped == itif_pkg::DivideAddr) begin
            tmr_wr_o.dv_hi_we = 1'b1;
            tmr_wr_o.dv_hi    = write_data_i[7:0];
          end else if (mapped == itif_pkg::DivideAddr + 24'd1) begin
            tmr_wr_o.dv_lo_we = 1'b1;
            tmr_wr_o.dv_lo    = write_data_i[7:0];
          end else if (off == itif_pkg::IcHiOff) begin
            ic_wr_o.hi_we = 1'b1;
            ic_wr_o.hi    = write_data_i[7:0];
          end else if (off == itif_pkg::IcLoOff) begin
            ic_wr_o.lo_we = 1'b1;
            ic_wr_o.lo    = write_data_i[7:0];
          end
        end
      end
      itif_pkg::ACT_WR_WORD: begin
        if (wr_ok) begin
          if (mapped == itif_pkg::PrescaleAddr) begin
            tmr_wr_o.ps_hi_we = 1'b1;
            tmr_wr_o.ps_lo_we = 1'b1;
            tmr_wr_o.ps_hi    = write_data_i[15:8];
            tmr_wr_o.ps_lo    = write_data_i[7:0];
          end else if (mapped == itif_pkg::DivideAddr) begin
            tmr_wr_o.dv_hi_we = 1'b1;
            tmr_wr_o.dv_lo_we = 1'b1;
            tmr_wr_o.dv_hi    = write_data_i[15:8];
            tmr_wr_o.dv_lo    = write_data_i[7:0];
          end else begin
            if (mapped == itif_pkg::IntFlagAddr) begin
              ic_wr_o.clr = write_data_i[itif_pkg::ClrMsb:itif_pkg::ClrLsb];
            end
            // high data byte lands at off, low data byte at off+1
            if (off == itif_pkg::IcHiOff) begin
              ic_wr_o.hi_we = 1'b1;
              ic_wr_o.hi    = write_data_i[15:8];
            end else if (off1 == itif_pkg::IcHiOff) begin
              ic_wr_o.hi_we = 1'b1;
              ic_wr_o.hi    = write_data_i[7:0];
            end
            if (off == itif_pkg::IcLoOff) begin
              ic_wr_o.lo_we = 1'b1;
              ic_wr_o.lo    = write_data_i[15:8];
            end else if (off1 == itif_pkg::IcLoOff) begin
              ic_wr_o.lo_we = 1'b1;
              ic_wr_o.lo    = write_data_i[7:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // reads decode the raw address, no mirroring
  always_comb begin
    roff        = address_i[13:0];
    roff1       = roff + 14'd1;
    read_data_o = '0;
    unique case (action_i)
      itif_pkg::ACT_RD_BYTE: begin
        if (itif_pkg::left_out(address_i)) begin
          read_data_o = '0;
        end else if (address_i == itif_pkg::PrescaleAddr) begin
          read_data_o = {8'h00, prescale_i[15:8]};
        end else if (address_i == itif_pkg::PrescaleAddr + 24'd1) begin
          read_data_o = {8'h00, prescale_i[7:0]};
        end else if (address_i == itif_pkg::DivideAddr) begin
          read_data_o = {8'h00, divide_i[15:8]};
        end else if (address_i == itif_pkg::DivideAddr + 24'd1) begin
          read_data_o = {8'h00, divide_i[7:0]};
        end else begin
          read_data_o = {8'h00, itif_pkg::ic_byte(roff, int_control_i)};
        end
      end
      itif_pkg::ACT_RD_WORD: begin
        if (address_i == itif_pkg::IntFlagAddr) begin
          read_data_o = {{(16 - itif_pkg::NumSrc){1'b0}}, pending_i};
        end else if (address_i == itif_pkg::HcAddr || itif_pkg::left_out(address_i)) begin
          read_data_o = '0;
        end else if (address_i == itif_pkg::PrescaleAddr) begin
          read_data_o = prescale_i;
        end else if (address_i == itif_pkg::DivideAddr) begin
          read_data_o = divide_i;
        end else begin
          read_data_o = {itif_pkg::ic_byte(roff, int_control_i),
                         itif_pkg::ic_byte(roff1, int_control_i)};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/itif_timer.sv]
module itif_timer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   tick_i,
  input  logic [15:0]            cycles_i,
  input  itif_pkg::itif_tmr_wr_t wr_i,
  output logic [15:0]            prescale_o,
  output logic [15:0]            divide_o,
  output logic                   fired_o
);

  logic [15:0]               prescale_q, prescale_d;
  logic [15:0]               divide_q, divide_d;
  logic [itif_pkg::CntW-1:0] countdown_q, countdown_d;
  logic [itif_pkg::CntW-1:0] product;
  logic                      any_wr;
  logic                      running;

  assign any_wr  = wr_i.ps_hi_we | wr_i.ps_lo_we | wr_i.dv_hi_we | wr_i.dv_lo_we;
  assign running = tick_i && (prescale_q != 16'd0);
  assign fired_o = running && (countdown_q <= {{(itif_pkg::CntW - 16){1'b0}}, cycles_i});

  always_comb begin
    prescale_d = {wr_i.ps_hi_we ? wr_i.ps_hi : prescale_q[15:8],
                  wr_i.ps_lo_we ? wr_i.ps_lo : prescale_q[7:0]};
    divide_d   = {wr_i.dv_hi_we ? wr_i.dv_hi : divide_q[15:8],
                  wr_i.dv_lo_we ? wr_i.dv_lo : divide_q[7:0]};
    // on a tick the write enables are low, so this is the current reload
    product    = ({{(itif_pkg::CntW - 16){1'b0}}, prescale_d} +
                  {{(itif_pkg::CntW - 1){1'b0}}, 1'b1}) *
                 ({{(itif_pkg::CntW - 16){1'b0}}, divide_d} +
                  {{(itif_pkg::CntW - 1){1'b0}}, 1'b1});

    countdown_d = countdown_q;
    if (any_wr || fired_o) begin
      countdown_d = product;
    end else if (running) begin
      countdown_d = countdown_q - {{(itif_pkg::CntW - 16){1'b0}}, cycles_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q  <= '0;
      divide_q    <= '0;
      countdown_q <= '0;
    end else if (step_i) begin
      prescale_q  <= prescale_d;
      divide_q    <= divide_d;
      countdown_q <= countdown_d;
    end
  end

  assign prescale_o = prescale_q;
  assign divide_o   = divide_q;

endmodule

[sv/interval_timer_interrupt_flags_unit.sv]
// Path: input beat passes through the input register, then the result register.
// Throughput: one beat per cycle while the result side is not stalled; the only path of note is the 17x17 reload
// multiply feeding the countdown register.
// Reset: pending flags, control word, prescaler, divider and countdown clear to 0,
// so the timer stays stopped until the prescaler is written; both stages empty.
module interval_timer_interrupt_flags_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] action, [26:3] address, [42:27] write_data, [45:43] source,
  // [61:46] tick_cycles, [63:62] zero
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] read_data, [16] timer_fired, [17] cpu_irq_request,
  // [22:18] pending_flags, [23] zero
  output logic [23:0] m_axis_tdata
);

  logic                          in_valid_q;
  logic [2:0]                    action_q;
  logic [23:0]                   address_q;
  logic [15:0]                   write_data_q;
  logic [2:0]                    source_q;
  logic [15:0]                   tick_cycles_q;

  logic                          out_valid_q;
  logic [23:0]                   out_data_q;

  logic [itif_pkg::NumSrc-1:0]   pending_q, pending_d;
  logic [15:0]                   int_control_q, int_control_d;

  logic                          advance;
  logic                          in_take;
  itif_pkg::itif_tmr_wr_t        tmr_wr;
  itif_pkg::itif_ic_wr_t         ic_wr;
  logic [15:0]                   read_data;
  logic [15:0]                   prescale;
  logic [15:0]                   divide;
  logic                          fired;
  logic                          irq;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q      <= s_axis_tdata[2:0];
      address_q     <= s_axis_tdata[26:3];
      write_data_q  <= s_axis_tdata[42:27];
      source_q      <= s_axis_tdata[45:43];
      tick_cycles_q <= s_axis_tdata[61:46];
    end
  end

  itif_bus_dec u_dec (
    .action_i      (action_q),
    .address_i     (address_q),
    .write_data_i  (write_data_q),
    .pending_i     (pending_q),
    .int_control_i (int_control_q),
    .prescale_i    (prescale),
    .divide_i      (divide),
    .tmr_wr_o      (tmr_wr),
    .ic_wr_o       (ic_wr),
    .read_data_o   (read_data)
  );

  itif_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .tick_i     (action_q == itif_pkg::ACT_TICK),
    .cycles_i   (tick_cycles_q),
    .wr_i       (tmr_wr),
    .prescale_o (prescale),
    .divide_o   (divide),
    .fired_o    (fired)
  );

  assign irq = fired && int_control_q[itif_pkg::TimerBit];

  always_comb begin
    pending_d = pending_q & ~ic_wr.clr;
    if (action_q == itif_pkg::ACT_RAISE && source_q <= itif_pkg::MaxSrc) begin
      pending_d[source_q] = 1'b1;
    end
    if (fired) begin
      pending_d[itif_pkg::TimerBit] = 1'b1;
    end
    int_control_d = {ic_wr.hi_we ? ic_wr.hi : int_control_q[15:8],
                     ic_wr.lo_we ? ic_wr.lo : int_control_q[7:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= '0;
      int_control_q <= '0;
    end else if (advance) begin
      pending_q     <= pending_d;
      int_control_q <= int_control_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {1'b0, pending_d, irq, fired, read_data};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[sv/itif_checker.sv]
`include "interval_timer_interrupt_flags_unit_macros.svh"

module itif_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata[63:62] == 2'b00);

  // a CPU interrupt request only comes with a timer expiry
  `ITIF_ASSERT_IMP(a_irq_needs_fire, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[17], m_axis_tdata[16])
  // an expiry always leaves the timer flag pending
  `ITIF_ASSERT_IMP(a_fire_sets_flag, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[16], m_axis_tdata[21])
  // input side only backs up when the result register is full and stalled
  `ITIF_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // stalled result beat holds
  `ITIF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // an input beat taken while the output side is ready shows up as a result unless the output stalls
  `ITIF_ASSERT_NXT(a_in_moves, clk_i, rst_ni, in_beat && m_axis_tready, ##1 (m_axis_tvalid || !m_axis_tready))

endmodule

bind interval_timer_interrupt_flags_unit itif_checker u_itif_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
